// File: sv/rainbow_pattern_pixel_generator_top_assert.svh
// Assertion helpers shared by the checker.
`ifndef RAINBOW_PATTERN_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define RAINBOW_PATTERN_PIXEL_GENERATOR_TOP_ASSERT_SVH

// Condition checked on every clock edge outside reset.
`define RPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rpg_pkg.sv
package rpg_pkg;

  localparam int unsigned MaxDimLog2 = 12;
  localparam int unsigned CoordW     = 12;
  localparam int unsigned FracW      = CoordW + 1;
  localparam int unsigned LevelW     = 16;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned DimLog2W   = 4;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CFG_WIDTH_LOG2  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT_LOG2 = 2'd1;

  localparam logic [DimLog2W-1:0] DimLog2Reset = 4'd8;
  localparam logic [ChanW-1:0]    AlphaOpaque  = 8'hFF;

  // hue sectors: which channel is full and which one ramps
  localparam logic [2:0] SEC_R_GUP = 3'd0;
  localparam logic [2:0] SEC_G_RDN = 3'd1;
  localparam logic [2:0] SEC_G_BUP = 3'd2;
  localparam logic [2:0] SEC_B_GDN = 3'd3;
  localparam logic [2:0] SEC_B_RUP = 3'd4;
  localparam logic [2:0] SEC_R_BDN = 3'd5;

  typedef struct packed {
    logic [DimLog2W-1:0] wl;
    logic [DimLog2W-1:0] hl;
  } dims_t;

  typedef struct packed {
    logic [2:0]          sector;
    logic [FracW-1:0]    frac;
    logic [DimLog2W-1:0] wl;
  } hue_t;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } stage_en_t;

  // 0.5 + 0.5*sin(phase) in Q0.16, phase as a 32-bit fraction of a turn
  function automatic logic [LevelW-1:0] sine_level(logic [31:0] phase);
    logic [63:0] one;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] h;
    logic [63:0] v;
    one = 64'h4000_0000;
    u   = {34'b0, phase[29:0]};
    if (phase[30]) begin
      u = one - u;
    end
    x  = (u * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = one - x2 / 64'd110;
    t  = one - ((x2 * t) >> 30) / 64'd72;
    t  = one - ((x2 * t) >> 30) / 64'd42;
    t  = one - ((x2 * t) >> 30) / 64'd20;
    t  = one - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    if (s > one) begin
      s = one;
    end
    h = (s + 64'h4000) >> 15;
    if (phase[31]) begin
      v = 64'd32768 - h;
    end else begin
      v = 64'd32768 + h;
    end
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[LevelW-1:0];
  endfunction

endpackage

// File: sv/rainbow_pattern_pixel_generator_top.sv
// A request accepted on s_axis passes through four register stages (coordinate
// decode, sine ROM registered read, ramp multiply, channel select and byte
// scaling) before its pixel shows on m_axis.
// Throughput: one request per cycle, stalls only when m_axis_tready is low.
// Reset (rst_ni low, asynchronous): all stages empty, width_log2 and
// height_log2 back to 8. The sine ROM is constant, so no clearing pass.
module rainbow_pattern_pixel_generator_top #(
  parameter int unsigned SINE_ENTRIES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [23:0]                           s_axis_tdata,  // column, row
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [31:0]                           m_axis_tdata,  // red, green, blue, alpha
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rpg_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [rpg_pkg::DimLog2W-1:0]          cfg_data_i
);

  rpg_pkg::stage_en_t                en;
  rpg_pkg::dims_t                    dims;
  rpg_pkg::hue_t                     coord_hue, rom_hue;
  logic [$clog2(SINE_ENTRIES)-1:0]   sine_idx;
  logic [rpg_pkg::LevelW-1:0]        level;
  logic [rpg_pkg::ChanW-1:0]         red, green, blue;
  logic a_valid_q, a_valid_d, b_valid_q, b_valid_d;
  logic c_valid_q, c_valid_d, d_valid_q, d_valid_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    en.d = !d_valid_q || m_axis_tready;
    en.c = !c_valid_q || en.d;
    en.b = !b_valid_q || en.c;
    en.a = !a_valid_q || en.b;
    a_valid_d = en.a ? s_axis_tvalid : a_valid_q;
    b_valid_d = en.b ? a_valid_q : b_valid_q;
    c_valid_d = en.c ? b_valid_q : c_valid_q;
    d_valid_d = en.d ? c_valid_q : d_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
      d_valid_q <= d_valid_d;
    end
  end

  rpg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .dims_o      (dims)
  );

  rpg_coord #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_coord (
    .clk_i    (clk_i),
    .en_i     (en),
    .dims_i   (dims),
    .column_i (s_axis_tdata[11:0]),
    .row_i    (s_axis_tdata[23:12]),
    .hue_o    (coord_hue),
    .idx_o    (sine_idx)
  );

  rpg_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (en),
    .idx_i   (sine_idx),
    .hue_i   (coord_hue),
    .level_o (level),
    .hue_o   (rom_hue)
  );

  rpg_shade u_shade (
    .clk_i   (clk_i),
    .en_i    (en),
    .level_i (level),
    .hue_i   (rom_hue),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue)
  );

  assign s_axis_tready = en.a;
  assign m_axis_tvalid = d_valid_q;
  assign m_axis_tdata  = {rpg_pkg::AlphaOpaque, blue, green, red};

endmodule

// File: sv/rpg_cfg_regs.sv
module rpg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rpg_pkg::DimLog2W-1:0]  cfg_data_i,
  output rpg_pkg::dims_t                dims_o
);

  logic [rpg_pkg::DimLog2W-1:0] width_log2_q, width_log2_d;
  logic [rpg_pkg::DimLog2W-1:0] height_log2_q, height_log2_d;

  localparam logic [rpg_pkg::DimLog2W-1:0] MaxLog2 =
    rpg_pkg::DimLog2W'(rpg_pkg::MaxDimLog2);

  always_comb begin
    width_log2_d  = width_log2_q;
    height_log2_d = height_log2_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        rpg_pkg::CFG_WIDTH_LOG2:  width_log2_d  = cfg_data_i;
        rpg_pkg::CFG_HEIGHT_LOG2: height_log2_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= rpg_pkg::DimLog2Reset;
      height_log2_q <= rpg_pkg::DimLog2Reset;
    end else begin
      width_log2_q  <= width_log2_d;
      height_log2_q <= height_log2_d;
    end
  end

  assign dims_o.wl = (width_log2_q > MaxLog2) ? MaxLog2 : width_log2_q;
  assign dims_o.hl = (height_log2_q > MaxLog2) ? MaxLog2 : height_log2_q;

endmodule

// File: sv/rpg_coord.sv
module rpg_coord #(
  parameter int unsigned SINE_ENTRIES = 1024
) (
  input  logic                                clk_i,
  input  rpg_pkg::stage_en_t                  en_i,
  input  rpg_pkg::dims_t                      dims_i,
  input  logic [rpg_pkg::CoordW-1:0]          column_i,
  input  logic [rpg_pkg::CoordW-1:0]          row_i,
  output rpg_pkg::hue_t                       hue_o,
  output logic [$clog2(SINE_ENTRIES)-1:0]     idx_o
);

  localparam int unsigned IdxW  = $clog2(SINE_ENTRIES);
  localparam int unsigned ProdW = rpg_pkg::CoordW + $clog2(SINE_ENTRIES + 1);
  localparam int unsigned PosW  = rpg_pkg::CoordW + 3;

  logic [rpg_pkg::CoordW-1:0] wmask, hmask, col_m, row_m, ramp;
  logic [PosW-1:0]            pos;
  logic [ProdW-1:0]           row_prod, row_scaled;
  rpg_pkg::hue_t              hue_d, hue_q;
  logic [IdxW-1:0]            idx_d, idx_q;

  always_comb begin
    wmask = rpg_pkg::CoordW'((rpg_pkg::FracW'(1) << dims_i.wl) - rpg_pkg::FracW'(1));
    hmask = rpg_pkg::CoordW'((rpg_pkg::FracW'(1) << dims_i.hl) - rpg_pkg::FracW'(1));
    col_m = column_i & wmask;
    row_m = row_i & hmask;

    // column * 6, split at the width boundary into sector and ramp
    pos          = (PosW'(col_m) << 2) + (PosW'(col_m) << 1);
    hue_d.sector = 3'(pos >> dims_i.wl);
    ramp         = pos[rpg_pkg::CoordW-1:0] & wmask;
    hue_d.wl     = dims_i.wl;
    if (hue_d.sector[0]) begin
      hue_d.frac = (rpg_pkg::FracW'(1) << dims_i.wl) - rpg_pkg::FracW'(ramp);
    end else begin
      hue_d.frac = rpg_pkg::FracW'(ramp);
    end

    row_prod   = ProdW'(row_m) * ProdW'(SINE_ENTRIES);
    row_scaled = row_prod >> dims_i.hl;
    if (row_scaled >= ProdW'(SINE_ENTRIES)) begin
      idx_d = IdxW'(SINE_ENTRIES - 1);
    end else begin
      idx_d = row_scaled[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      hue_q <= hue_d;
      idx_q <= idx_d;
    end
  end

  assign hue_o = hue_q;
  assign idx_o = idx_q;

endmodule

// File: sv/rpg_sine_rom.sv
module rpg_sine_rom #(
  parameter int unsigned SINE_ENTRIES = 1024
) (
  input  logic                                clk_i,
  input  rpg_pkg::stage_en_t                  en_i,
  input  logic [$clog2(SINE_ENTRIES)-1:0]     idx_i,
  input  rpg_pkg::hue_t                       hue_i,
  output logic [rpg_pkg::LevelW-1:0]          level_o,
  output rpg_pkg::hue_t                       hue_o
);

  typedef logic [rpg_pkg::LevelW-1:0] rom_t [SINE_ENTRIES];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] ph;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      ph   = (64'(k) << 32) / 64'(SINE_ENTRIES);
      r[k] = rpg_pkg::sine_level(ph[31:0]);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [rpg_pkg::LevelW-1:0] level_q;
  rpg_pkg::hue_t              hue_q;

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      level_q <= SineRom[idx_i];
      hue_q   <= hue_i;
    end
  end

  assign level_o = level_q;
  assign hue_o   = hue_q;

endmodule

// File: sv/rpg_shade.sv
module rpg_shade (
  input  logic                        clk_i,
  input  rpg_pkg::stage_en_t          en_i,
  input  logic [rpg_pkg::LevelW-1:0]  level_i,
  input  rpg_pkg::hue_t               hue_i,
  output logic [rpg_pkg::ChanW-1:0]   red_o,
  output logic [rpg_pkg::ChanW-1:0]   green_o,
  output logic [rpg_pkg::ChanW-1:0]   blue_o
);

  localparam int unsigned MulW = rpg_pkg::LevelW + rpg_pkg::FracW;

  logic [MulW-1:0]            ramp_prod;
  logic [rpg_pkg::LevelW-1:0] ramp_d, ramp_q, full_q;
  logic [2:0]                 sector_q;
  logic [rpg_pkg::LevelW-1:0] r_ch, g_ch, b_ch;
  logic [rpg_pkg::ChanW-1:0]  red_q, green_q, blue_q;

  // (ch * 255) >> 16
  function automatic logic [rpg_pkg::ChanW-1:0] to_byte(logic [rpg_pkg::LevelW-1:0] ch);
    logic [rpg_pkg::LevelW+7:0] p;
    p = {ch, 8'b0} - {8'b0, ch};
    return p[rpg_pkg::LevelW+7:rpg_pkg::LevelW];
  endfunction

  always_comb begin
    ramp_prod = MulW'(level_i) * MulW'(hue_i.frac);
    ramp_d    = rpg_pkg::LevelW'(ramp_prod >> hue_i.wl);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      ramp_q   <= ramp_d;
      full_q   <= level_i;
      sector_q <= hue_i.sector;
    end
  end

  always_comb begin
    r_ch = '0;
    g_ch = '0;
    b_ch = '0;
    case (sector_q)
      rpg_pkg::SEC_R_GUP: begin
        r_ch = full_q;
        g_ch = ramp_q;
      end
      rpg_pkg::SEC_G_RDN: begin
        r_ch = ramp_q;
        g_ch = full_q;
      end
      rpg_pkg::SEC_G_BUP: begin
        g_ch = full_q;
        b_ch = ramp_q;
      end
      rpg_pkg::SEC_B_GDN: begin
        g_ch = ramp_q;
        b_ch = full_q;
      end
      rpg_pkg::SEC_B_RUP: begin
        r_ch = ramp_q;
        b_ch = full_q;
      end
      default: begin
        r_ch = full_q;
        b_ch = ramp_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.d) begin
      red_q   <= to_byte(r_ch);
      green_q <= to_byte(g_ch);
      blue_q  <= to_byte(b_ch);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// File: sv/rpg_checker.sv
`include "rainbow_pattern_pixel_generator_top_assert.svh"

module rpg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `RPG_ASSERT_ALWAYS(a_alpha_opaque, m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'hFF), "alpha not opaque")
  `RPG_ASSERT_ALWAYS(a_one_chan_zero, m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'h00 || m_axis_tdata[15:8] == 8'h00 || m_axis_tdata[23:16] == 8'h00), "no channel is zero")
  `RPG_ASSERT_ALWAYS(a_chan_below_max, m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'hFF && m_axis_tdata[15:8] != 8'hFF && m_axis_tdata[23:16] != 8'hFF), "channel at 255")
  `RPG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind rainbow_pattern_pixel_generator_top rpg_checker u_rpg_checker (.*);

// File: sim/tb_rainbow_pattern_pixel_generator_top.sv
module tb_rainbow_pattern_pixel_generator_top;

  localparam int unsigned SINE_N      = 1024;
  localparam int unsigned PIPE_SETTLE = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [63:0] QUARTER     = 64'h4000_0000;
  localparam logic [rpg_pkg::CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [rpg_pkg::CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [rpg_pkg::CoordW-1:0] row;
    logic [rpg_pkg::CoordW-1:0] column;
  } pixel_req_t;

  typedef struct packed {
    logic [rpg_pkg::ChanW-1:0] alpha;
    logic [rpg_pkg::ChanW-1:0] blue;
    logic [rpg_pkg::ChanW-1:0] green;
    logic [rpg_pkg::ChanW-1:0] red;
  } rgba_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [23:0]                  s_axis_tdata = '0;  // column, row
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [31:0]                  m_axis_tdata;       // red, green, blue, alpha
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [rpg_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [rpg_pkg::DimLog2W-1:0] cfg_data_i = '0;

  logic [rpg_pkg::DimLog2W-1:0] width_sel = rpg_pkg::DimLog2Reset;
  logic [rpg_pkg::DimLog2W-1:0] height_sel = rpg_pkg::DimLog2Reset;
  logic [rpg_pkg::LevelW-1:0]   level_rom [SINE_N];

  pixel_req_t pending_q [$];
  rgba_t      expected_q [$];
  logic       quiet = 1'b0;
  int         src_gap;
  int         sink_gap;
  int         mismatches = 0;
  int         cycle_count = 0;

  rainbow_pattern_pixel_generator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // brightness 0.5 + 0.5*sin for table entry k, Q0.16
  function automatic logic [rpg_pkg::LevelW-1:0] wave_level(int unsigned k);
    int unsigned divs [4] = '{72, 42, 20, 6};
    logic [63:0] ph, u, x, x2, t, s, h, v;
    ph = (64'(k) << 32) / SINE_N;
    u = ph & (QUARTER - 1);
    if (ph[30]) begin
      u = QUARTER - u;
    end
    x  = (u * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = QUARTER - x2 / 64'd110;
    foreach (divs[i]) begin
      t = QUARTER - ((x2 * t) >> 30) / divs[i];
    end
    s = (x * t) >> 30;
    if (s > QUARTER) begin
      s = QUARTER;
    end
    h = (s + 64'h4000) >> 15;
    v = ph[31] ? 64'd32768 - h : 64'd32768 + h;
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[rpg_pkg::LevelW-1:0];
  endfunction

  function automatic rgba_t pixel_rgba(input logic [rpg_pkg::CoordW-1:0] col,
                                       input logic [rpg_pkg::CoordW-1:0] line_y);
    int unsigned wl, hl, wmask, cx, ry, pos, ramp, idx;
    logic [2:0]  sector;
    logic [63:0] lvl, rise, fall, r, g, b;
    rgba_t       px;
    wl = (width_sel > rpg_pkg::MaxDimLog2) ? rpg_pkg::MaxDimLog2 : width_sel;
    hl = (height_sel > rpg_pkg::MaxDimLog2) ? rpg_pkg::MaxDimLog2 : height_sel;
    wmask = (32'd1 << wl) - 1;
    cx = col & wmask;
    ry = line_y & ((32'd1 << hl) - 1);
    pos = cx * 6;
    sector = 3'(pos >> wl);
    ramp = pos & wmask;
    idx = (ry * SINE_N) >> hl;
    if (idx >= SINE_N) begin
      idx = SINE_N - 1;
    end
    lvl  = level_rom[idx];
    rise = (lvl * ramp) >> wl;
    fall = (lvl * ((64'd1 << wl) - ramp)) >> wl;
    r = '0;
    g = '0;
    b = '0;
    case (sector)
      rpg_pkg::SEC_R_GUP: begin
        r = lvl;
        g = rise;
      end
      rpg_pkg::SEC_G_RDN: begin
        r = fall;
        g = lvl;
      end
      rpg_pkg::SEC_G_BUP: begin
        g = lvl;
        b = rise;
      end
      rpg_pkg::SEC_B_GDN: begin
        g = fall;
        b = lvl;
      end
      rpg_pkg::SEC_B_RUP: begin
        r = rise;
        b = lvl;
      end
      default: begin
        r = lvl;
        b = fall;
      end
    endcase
    px.red   = 8'((r * 64'd255) >> 16);
    px.green = 8'((g * 64'd255) >> 16);
    px.blue  = 8'((b * 64'd255) >> 16);
    px.alpha = rpg_pkg::AlphaOpaque;
    return px;
  endfunction

  function automatic void check_pixel(input rgba_t got);
    rgba_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected pixel %h with nothing pending", got);
      end
      return;
    end
    want = expected_q.pop_front();
    if (got.red !== want.red || got.green !== want.green ||
        got.blue !== want.blue || got.alpha !== want.alpha) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                 want.red, want.green, want.blue, want.alpha,
                 got.red, got.green, got.blue, got.alpha);
      end
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q = {expected_q, pixel_rgba(s_axis_tdata[11:0], s_axis_tdata[23:12])};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          src_gap <= $urandom_range(0, 7);
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_axis_tdata <= pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_pixel(m_axis_tdata);
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        sink_gap <= $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_pixel(input int unsigned col, input int unsigned line_y);
    pixel_req_t req;
    req.column = col[rpg_pkg::CoordW-1:0];
    req.row = line_y[rpg_pkg::CoordW-1:0];
    pending_q = {pending_q, req};
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rpg_pkg::CfgIdxW-1:0] idx,
                           input logic [rpg_pkg::DimLog2W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i);
    while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      rpg_pkg::CFG_WIDTH_LOG2:  width_sel = val;
      rpg_pkg::CFG_HEIGHT_LOG2: height_sel = val;
      default: ;
    endcase
  endtask

  task automatic set_dims(input logic [rpg_pkg::DimLog2W-1:0] w,
                          input logic [rpg_pkg::DimLog2W-1:0] h);
    drain();
    write_reg(rpg_pkg::CFG_WIDTH_LOG2, w);
    write_reg(rpg_pkg::CFG_HEIGHT_LOG2, h);
  endtask

  // mostly in-range coordinates, some with stray high bits
  task automatic run_phase(input int count);
    int unsigned sel, wl, hl;
    logic [31:0] cx, ry, wmask, hmask;
    wl = (width_sel > rpg_pkg::MaxDimLog2) ? rpg_pkg::MaxDimLog2 : width_sel;
    hl = (height_sel > rpg_pkg::MaxDimLog2) ? rpg_pkg::MaxDimLog2 : height_sel;
    wmask = (32'd1 << wl) - 1;
    hmask = (32'd1 << hl) - 1;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      cx = $urandom & wmask;
      ry = $urandom & hmask;
      if (sel == 0) begin
        cx = wmask;
      end else if (sel == 1) begin
        ry = hmask;
      end else if (sel >= 8) begin
        cx = $urandom;
        ry = $urandom;
      end
      add_pixel(cx & 32'hFFF, ry & 32'hFFF);
    end
  endtask

  initial begin
    for (int k = 0; k < SINE_N; k++) begin
      level_rom[k] = wave_level(k);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset dims 8/8: sector starts and ends, sine peak and trough, wrap
    add_pixel(0, 0);
    add_pixel(255, 64);
    add_pixel(4095, 4095);
    add_pixel(42, 64);
    add_pixel(43, 64);
    add_pixel(86, 128);
    add_pixel(127, 32);
    add_pixel(128, 192);
    add_pixel(170, 200);
    add_pixel(171, 255);
    add_pixel(213, 100);
    add_pixel(214, 1);
    add_pixel(254, 64);
    add_pixel(1, 0);
    add_pixel(2048 + 43, 256 + 64);
    add_pixel(0, 192);

    drain();
    write_reg(CFG_SPARE_A, 4'hF);
    write_reg(CFG_SPARE_B, 4'h0);
    add_pixel(100, 64);
    add_pixel(200, 192);

    set_dims(4'd0, 4'd0);
    add_pixel(4095, 4095);
    run_phase(30);

    set_dims(4'd12, 4'd12);
    add_pixel(4095, 4095);
    add_pixel(0, 1024);
    add_pixel(2048, 3072);
    run_phase(50);

    set_dims(4'd15, 4'd13);
    add_pixel(4095, 1024);
    run_phase(50);

    set_dims(4'd1, 4'd2);
    run_phase(40);
    set_dims(4'd4, 4'd10);
    run_phase(50);
    set_dims(4'd11, 4'd3);
    run_phase(50);
    set_dims(4'd6, 4'd11);
    run_phase(50);
    repeat (3) begin
      set_dims(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      run_phase(50);
    end

    set_dims(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    quiet = 1'b1;
    run_phase(60);

    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
